FILE: sv/qte_pkg.sv
package qte_pkg;

   localparam int CORDIC_ITERATIONS = 16;
   localparam int CORDIC_STEPS = (CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS;
   localparam int CW = 38;
   localparam int ISQ_STEPS = 31;
   localparam int ISQ_W = 62;

   localparam logic [14:0] GIMBAL_THRESHOLD_RESET = 15'd16383;
   localparam logic signed [CW-1:0] CORDIC_ONE = CW'(1) <<< 30;
   localparam logic [31:0] ANGLE_PI = 32'h8000_0000;
   localparam logic signed [15:0] PITCH_UP = 16'sd16384;
   localparam logic signed [15:0] PITCH_DOWN = -16'sd16384;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [31:0] pos_x_in;
      logic signed [31:0] pos_y_in;
      logic signed [31:0] pos_z_in;
   } req_type;

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
      logic signed [31:0] pos_x_out;
      logic signed [31:0] pos_y_out;
      logic signed [31:0] pos_z_out;
   } rsp_type;

   // atan(2^-i) as a binary angle, 2^31 = pi
   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] val;
      unique case (idx)
         5'd0:  val = 32'h20000000;
         5'd1:  val = 32'h12E4051E;
         5'd2:  val = 32'h09FB385B;
         5'd3:  val = 32'h051111D4;
         5'd4:  val = 32'h028B0D43;
         5'd5:  val = 32'h0145D7E1;
         5'd6:  val = 32'h00A2F61E;
         5'd7:  val = 32'h00517C55;
         5'd8:  val = 32'h0028BE53;
         5'd9:  val = 32'h00145F2F;
         5'd10: val = 32'h000A2F98;
         5'd11: val = 32'h000517CC;
         5'd12: val = 32'h00028BE6;
         5'd13: val = 32'h000145F3;
         5'd14: val = 32'h0000A2FA;
         5'd15: val = 32'h0000517D;
         5'd16: val = 32'h000028BE;
         5'd17: val = 32'h0000145F;
         5'd18: val = 32'h00000A30;
         5'd19: val = 32'h00000518;
         5'd20: val = 32'h0000028C;
         5'd21: val = 32'h00000146;
         5'd22: val = 32'h000000A3;
         5'd23: val = 32'h00000051;
         default: val = 32'h0;
      endcase
      return val;
   endfunction

   // round half up to a 16-bit binary angle, wrapping
   function automatic logic signed [15:0] to_angle16(input logic [31:0] a);
      logic [31:0] t;
      t = a + 32'h0000_8000;
      return $signed(t[31:16]);
   endfunction

endpackage

FILE: sv/qte_cordic.sv
module qte_cordic import qte_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [CW-1:0] in_x,
   input  logic signed [CW-1:0] in_y,
   output logic                 out_valid,
   output logic [31:0]          out_z
);

   logic signed [CW-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [CW-1:0] y_ff [0:CORDIC_STEPS];
   logic [31:0]          z_ff [0:CORDIC_STEPS];
   logic                 zero_ff [0:CORDIC_STEPS];
   logic                 vld_ff [0:CORDIC_STEPS];

   logic signed [CW-1:0] x_in [0:CORDIC_STEPS];
   logic signed [CW-1:0] y_in [0:CORDIC_STEPS];
   logic [31:0]          z_in [0:CORDIC_STEPS];
   logic                 zero_in [0:CORDIC_STEPS];

   always_comb begin
      // fold the left half plane over, start at pi
      zero_in[0] = (in_x == '0) && (in_y == '0);
      if (in_x < 0) begin
         x_in[0] = -in_x;
         y_in[0] = -in_y;
         z_in[0] = ANGLE_PI;
      end else begin
         x_in[0] = in_x;
         y_in[0] = in_y;
         z_in[0] = '0;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         zero_in[i+1] = zero_ff[i];
         if (y_ff[i] >= 0) begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + atan_entry(5'(i));
         end else begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - atan_entry(5'(i));
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= CORDIC_STEPS; i++) begin
         x_ff[i] <= x_in[i];
         y_ff[i] <= y_in[i];
         z_ff[i] <= z_in[i];
         zero_ff[i] <= zero_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= CORDIC_STEPS; i++) vld_ff[i] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i <= CORDIC_STEPS; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   assign out_valid = vld_ff[CORDIC_STEPS];
   assign out_z = zero_ff[CORDIC_STEPS] ? 32'h0 : z_ff[CORDIC_STEPS];

endmodule

FILE: sv/quaternion_to_euler_angles_top.sv
// A request passes the registers of stages A to D, 31 square-root steps, 17 CORDIC stages
// and the response register before rsp_valid rises.
// Throughput: one pose per cycle; busy is never asserted.
// The receiver cannot stall; nothing in the pipeline waits.
// Reset (synchronous) clears every valid bit and sets gimbal_threshold to 16383.
module quaternion_to_euler_angles_top import qte_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   output logic        rsp_valid,
   output rsp_type     rsp_payload,
   input  logic        csr_wr_en,
   input  logic [14:0] csr_wr_data
);

   localparam int LATENCY = ISQ_STEPS + CORDIC_STEPS + 6;

   typedef struct packed {
      logic signed [31:0]   pos_x;
      logic signed [31:0]   pos_y;
      logic signed [31:0]   pos_z;
      logic                 gim_pos;
      logic                 gim_neg;
   } side_type;

   typedef struct packed {
      side_type             side;
      logic signed [31:0]   s;
      logic signed [CW-1:0] yaw_x;
      logic signed [CW-1:0] yaw_y;
      logic signed [CW-1:0] roll_x;
      logic signed [CW-1:0] roll_y;
   } carry_type;

   logic [14:0] thr_ff;

   // stage A: request register
   req_type a_req_ff;
   logic    a_vld_ff;

   // stage B: products
   req_type            b_req_ff;
   logic               b_vld_ff;
   logic signed [31:0] b_wy_ff, b_xz_ff, b_wz_ff, b_xy_ff, b_wx_ff;
   logic signed [31:0] b_yz_ff, b_xx_ff, b_yy_ff, b_zz_ff;

   // stage C: sums, branch decision
   carry_type c_car_ff, c_car_in;
   logic      c_vld_ff;

   // stage D: pitch radicand
   carry_type        d_car_ff;
   logic [ISQ_W-1:0] d_v_ff, d_v_in;
   logic             d_vld_ff;

   // square-root pipeline
   carry_type        q_car_ff [0:ISQ_STEPS-1];
   logic [ISQ_W-1:0] q_v_ff [0:ISQ_STEPS-1];
   logic [ISQ_W-1:0] q_r_ff [0:ISQ_STEPS-1];
   logic [ISQ_W-1:0] q_v_in [0:ISQ_STEPS-1];
   logic [ISQ_W-1:0] q_r_in [0:ISQ_STEPS-1];
   logic             q_vld_ff [0:ISQ_STEPS-1];

   // side data alongside the CORDICs
   side_type e_side_ff [0:CORDIC_STEPS];

   rsp_type rsp_ff, rsp_in;
   logic    rsp_vld_ff;

   logic        yaw_vld, pitch_vld, roll_vld;
   logic [31:0] yaw_z, pitch_z, roll_z;

   logic accept;
   assign busy = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= GIMBAL_THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         for (int i = 0; i < ISQ_STEPS; i++) q_vld_ff[i] <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= accept;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
         q_vld_ff[0] <= d_vld_ff;
         for (int i = 1; i < ISQ_STEPS; i++) q_vld_ff[i] <= q_vld_ff[i-1];
         rsp_vld_ff <= yaw_vld;
      end
   end

   always_ff @(posedge clock) begin
      a_req_ff <= req_payload;
      b_req_ff <= a_req_ff;
      b_wy_ff <= 32'($signed(a_req_ff.quat_w) * $signed(a_req_ff.quat_y));
      b_xz_ff <= 32'($signed(a_req_ff.quat_x) * $signed(a_req_ff.quat_z));
      b_wz_ff <= 32'($signed(a_req_ff.quat_w) * $signed(a_req_ff.quat_z));
      b_xy_ff <= 32'($signed(a_req_ff.quat_x) * $signed(a_req_ff.quat_y));
      b_wx_ff <= 32'($signed(a_req_ff.quat_w) * $signed(a_req_ff.quat_x));
      b_yz_ff <= 32'($signed(a_req_ff.quat_y) * $signed(a_req_ff.quat_z));
      b_xx_ff <= 32'($signed(a_req_ff.quat_x) * $signed(a_req_ff.quat_x));
      b_yy_ff <= 32'($signed(a_req_ff.quat_y) * $signed(a_req_ff.quat_y));
      b_zz_ff <= 32'($signed(a_req_ff.quat_z) * $signed(a_req_ff.quat_z));
   end

   // stage C
   logic signed [32:0] c_d, c_lim, c_yaw_sum, c_roll_sum;
   logic [32:0]        c_yaw_sq, c_roll_sq;

   always_comb begin
      c_d = $signed({b_wy_ff[31], b_wy_ff}) - $signed({b_xz_ff[31], b_xz_ff});
      c_lim = $signed({3'b000, thr_ff, 15'b0});
      c_yaw_sum = $signed({b_wz_ff[31], b_wz_ff}) + $signed({b_xy_ff[31], b_xy_ff});
      c_roll_sum = $signed({b_wx_ff[31], b_wx_ff}) + $signed({b_yz_ff[31], b_yz_ff});
      c_yaw_sq = {1'b0, b_yy_ff} + {1'b0, b_zz_ff};
      c_roll_sq = {1'b0, b_xx_ff} + {1'b0, b_yy_ff};

      c_car_in.side.pos_x = b_req_ff.pos_x_in;
      c_car_in.side.pos_y = b_req_ff.pos_y_in;
      c_car_in.side.pos_z = b_req_ff.pos_z_in;
      c_car_in.side.gim_pos = c_d > c_lim;
      c_car_in.side.gim_neg = c_d < -c_lim;

      // saturate 2D to [-1, 1]
      priority if (c_d > 33'sd536870912) begin
         c_car_in.s = 32'sd1073741824;
      end else if (c_d < -33'sd536870912) begin
         c_car_in.s = -32'sd1073741824;
      end else begin
         c_car_in.s = $signed({c_d[30:0], 1'b0});
      end

      if (c_car_in.side.gim_pos || c_car_in.side.gim_neg) begin
         c_car_in.yaw_y = CW'($signed({b_req_ff.quat_x, 15'b0}));
         c_car_in.yaw_x = CW'($signed({b_req_ff.quat_w, 15'b0}));
      end else begin
         c_car_in.yaw_y = CW'($signed({c_yaw_sum, 1'b0}));
         c_car_in.yaw_x = CORDIC_ONE - CW'({c_yaw_sq, 1'b0});
      end
      c_car_in.roll_y = CW'($signed({c_roll_sum, 1'b0}));
      c_car_in.roll_x = CORDIC_ONE - CW'({c_roll_sq, 1'b0});
   end

   always_ff @(posedge clock) begin
      c_car_ff <= c_car_in;
   end

   // stage D: 1 - s^2 in Q2.60
   logic signed [31:0] d_neg_s;
   logic [30:0]        d_abs;
   logic [ISQ_W-1:0]   d_sq;

   always_comb begin
      d_neg_s = -c_car_ff.s;
      d_abs = (c_car_ff.s < 0) ? d_neg_s[30:0] : c_car_ff.s[30:0];
      d_sq = ISQ_W'(d_abs) * ISQ_W'(d_abs);
      d_v_in = (ISQ_W'(1) << 60) - d_sq;
   end

   always_ff @(posedge clock) begin
      d_car_ff <= c_car_ff;
      d_v_ff <= d_v_in;
   end

   // square root, one result bit per stage
   logic [ISQ_W-1:0] q_src_v, q_src_r, q_bit, q_trial;

   always_comb begin
      for (int i = 0; i < ISQ_STEPS; i++) begin
         q_src_v = (i == 0) ? d_v_ff : q_v_ff[(i == 0) ? 0 : i - 1];
         q_src_r = (i == 0) ? '0 : q_r_ff[(i == 0) ? 0 : i - 1];
         q_bit = ISQ_W'(1) << (2 * (ISQ_STEPS - 1 - i));
         q_trial = q_src_r + q_bit;
         if (q_src_v >= q_trial) begin
            q_v_in[i] = q_src_v - q_trial;
            q_r_in[i] = (q_src_r >> 1) + q_bit;
         end else begin
            q_v_in[i] = q_src_v;
            q_r_in[i] = q_src_r >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_car_ff[0] <= d_car_ff;
      for (int i = 1; i < ISQ_STEPS; i++) q_car_ff[i] <= q_car_ff[i-1];
      for (int i = 0; i < ISQ_STEPS; i++) begin
         q_v_ff[i] <= q_v_in[i];
         q_r_ff[i] <= q_r_in[i];
      end
   end

   carry_type            q_last;
   logic signed [CW-1:0] pitch_x, pitch_y;

   assign q_last = q_car_ff[ISQ_STEPS-1];
   assign pitch_y = CW'(q_last.s);
   assign pitch_x = CW'({1'b0, q_r_ff[ISQ_STEPS-1][30:0]});

   qte_cordic u_yaw (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_vld_ff[ISQ_STEPS-1]),
      .in_x      (q_last.yaw_x),
      .in_y      (q_last.yaw_y),
      .out_valid (yaw_vld),
      .out_z     (yaw_z)
   );

   qte_cordic u_pitch (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_vld_ff[ISQ_STEPS-1]),
      .in_x      (pitch_x),
      .in_y      (pitch_y),
      .out_valid (pitch_vld),
      .out_z     (pitch_z)
   );

   qte_cordic u_roll (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_vld_ff[ISQ_STEPS-1]),
      .in_x      (q_last.roll_x),
      .in_y      (q_last.roll_y),
      .out_valid (roll_vld),
      .out_z     (roll_z)
   );

   always_ff @(posedge clock) begin
      e_side_ff[0] <= q_last.side;
      for (int i = 1; i <= CORDIC_STEPS; i++) e_side_ff[i] <= e_side_ff[i-1];
   end

   // output select
   side_type o_side;

   always_comb begin
      o_side = e_side_ff[CORDIC_STEPS];
      rsp_in.pos_x_out = o_side.pos_x;
      rsp_in.pos_y_out = o_side.pos_y;
      rsp_in.pos_z_out = o_side.pos_z;
      priority if (o_side.gim_pos) begin
         rsp_in.roll_angle = '0;
         rsp_in.pitch_angle = PITCH_UP;
         rsp_in.yaw_angle = to_angle16(32'h0 - {yaw_z[30:0], 1'b0});
      end else if (o_side.gim_neg) begin
         rsp_in.roll_angle = '0;
         rsp_in.pitch_angle = PITCH_DOWN;
         rsp_in.yaw_angle = to_angle16({yaw_z[30:0], 1'b0});
      end else begin
         rsp_in.roll_angle = to_angle16(roll_z);
         rsp_in.pitch_angle = to_angle16(pitch_z);
         rsp_in.yaw_angle = to_angle16(yaw_z);
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("request did not produce a response at fixed latency");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("response without matching request");

   a_cordic_lockstep: assert property (@(posedge clock) disable iff (reset)
      (yaw_vld == pitch_vld) && (yaw_vld == roll_vld))
      else $error("CORDIC lanes out of step");
`endif

endmodule
